>>> hdl/rieco_pkg.sv
// ----------------------------------------------------------------------------
// rieco_pkg
// Shared widths, codes and types of the relative input event coalescer.
// ----------------------------------------------------------------------------
package rieco_pkg;

  localparam int unsigned KIND_W        = 2;
  localparam int unsigned CODE_W        = 10;
  localparam int unsigned VALUE_W       = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned SUM_WIDTH_DEF = 24;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // event classes; everything that is not relative or key is dropped
  localparam logic [KIND_W-1:0] KIND_REL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEY = 2'd1;

  // relative axis codes
  localparam logic [CODE_W-1:0] AXIS_X      = 10'd0;
  localparam logic [CODE_W-1:0] AXIS_Y      = 10'd1;
  localparam logic [CODE_W-1:0] AXIS_HWHEEL = 10'd6;
  localparam logic [CODE_W-1:0] AXIS_VWHEEL = 10'd8;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP_SRC = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REMAP_DST = 2'd1;
  localparam logic [CODE_W-1:0]    REMAP_SRC_RST = 10'd99;
  localparam logic [CODE_W-1:0]    REMAP_DST_RST = 10'd210;

  typedef enum logic [1:0] {
    OUT_MOTION  = 2'd0,
    OUT_WHEEL   = 2'd1,
    OUT_PRESS   = 2'd2,
    OUT_RELEASE = 2'd3
  } out_type_e;

  // which results one input item left behind
  typedef struct packed {
    logic              has_motion;
    logic              has_wheel;
    logic              has_key;
    logic              key_press;
    logic [CODE_W-1:0] key_code;
  } bundle_flags_t;

endpackage

>>> hdl/rieco_evt_if.sv
// ----------------------------------------------------------------------------
// rieco_evt_if
// Input event channel: valid/ready with one raw device event.
// ----------------------------------------------------------------------------
interface rieco_evt_if;
  logic                                valid;
  logic                                ready;
  logic [rieco_pkg::KIND_W-1:0]        kind;
  logic [rieco_pkg::CODE_W-1:0]        event_code;
  logic signed [rieco_pkg::VALUE_W-1:0] event_value;
  logic                                batch_last;

  modport source (output valid, kind, event_code, event_value, batch_last, input ready);
  modport sink   (input valid, kind, event_code, event_value, batch_last, output ready);
endinterface

>>> hdl/rieco_res_if.sv
// ----------------------------------------------------------------------------
// rieco_res_if
// Result channel: valid/ready with one motion, wheel or key result.
// ----------------------------------------------------------------------------
interface rieco_res_if #(
  parameter int unsigned SUM_WIDTH = rieco_pkg::SUM_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    out_type;
  logic [rieco_pkg::CODE_W-1:0]  out_code;
  logic signed [SUM_WIDTH-1:0]   delta_x;
  logic signed [SUM_WIDTH-1:0]   delta_y;
  logic                          last_result;

  modport source (output valid, out_type, out_code, delta_x, delta_y, last_result,
                  input ready);
  modport sink   (input valid, out_type, out_code, delta_x, delta_y, last_result,
                  output ready);
endinterface

>>> hdl/rieco_cfg_if.sv
// ----------------------------------------------------------------------------
// rieco_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface rieco_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rieco_pkg::CFG_IDX_W-1:0] index;
  logic [rieco_pkg::CODE_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/rieco_accum.sv
// ----------------------------------------------------------------------------
// rieco_accum
// Saturating run accumulators, flush decision and key remap for one item.
// ----------------------------------------------------------------------------
module rieco_accum #(
  parameter int unsigned SUM_WIDTH = rieco_pkg::SUM_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  take_i,
  input  logic [rieco_pkg::KIND_W-1:0]          kind_i,
  input  logic [rieco_pkg::CODE_W-1:0]          code_i,
  input  logic signed [rieco_pkg::VALUE_W-1:0]  value_i,
  input  logic                                  last_i,
  input  logic [rieco_pkg::CODE_W-1:0]          remap_src_i,
  input  logic [rieco_pkg::CODE_W-1:0]          remap_dst_i,
  output logic                                  push_o,
  output rieco_pkg::bundle_flags_t              flags_o,
  output logic signed [SUM_WIDTH-1:0]           mot_x_o,
  output logic signed [SUM_WIDTH-1:0]           mot_y_o,
  output logic signed [SUM_WIDTH-1:0]           whl_x_o,
  output logic signed [SUM_WIDTH-1:0]           whl_y_o
);
  import rieco_pkg::*;

  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  logic signed [SUM_WIDTH-1:0] sum_x_q, sum_y_q, sum_h_q, sum_v_q;
  logic signed [SUM_WIDTH-1:0] sum_x_d, sum_y_d, sum_h_d, sum_v_d;
  logic signed [SUM_WIDTH:0]   value_ext;
  logic                        is_rel, is_key, flush;

  // one guard bit is enough since the delta is never wider than the sum
  function automatic logic signed [SUM_WIDTH-1:0] sat_add(
    input logic signed [SUM_WIDTH-1:0] acc,
    input logic signed [SUM_WIDTH:0]   v
  );
    logic signed [SUM_WIDTH:0] s;
    s = {acc[SUM_WIDTH-1], acc} + v;
    if (s[SUM_WIDTH] != s[SUM_WIDTH-1]) begin
      return s[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_WIDTH-1:0];
  endfunction

  assign value_ext = {{(SUM_WIDTH+1-VALUE_W){value_i[VALUE_W-1]}}, value_i};
  assign is_rel    = (kind_i == KIND_REL);
  assign is_key    = (kind_i == KIND_KEY);
  assign flush     = !is_rel || last_i;

  always_comb begin
    mot_x_o = sum_x_q;
    mot_y_o = sum_y_q;
    whl_x_o = sum_h_q;
    whl_y_o = sum_v_q;
    if (is_rel) begin
      case (code_i)
        AXIS_X:      mot_x_o = sat_add(sum_x_q, value_ext);
        AXIS_Y:      mot_y_o = sat_add(sum_y_q, value_ext);
        AXIS_HWHEEL: whl_x_o = sat_add(sum_h_q, value_ext);
        AXIS_VWHEEL: whl_y_o = sat_add(sum_v_q, value_ext);
        default: ;
      endcase
    end
  end

  always_comb begin
    flags_o.has_motion = flush && ((mot_x_o != '0) || (mot_y_o != '0));
    flags_o.has_wheel  = flush && ((whl_x_o != '0) || (whl_y_o != '0));
    flags_o.has_key    = is_key;
    flags_o.key_press  = (value_i != '0);
    flags_o.key_code   = (code_i == remap_src_i) ? remap_dst_i : code_i;
  end

  assign push_o = take_i && (flags_o.has_motion || flags_o.has_wheel || flags_o.has_key);

  assign sum_x_d = flush ? '0 : mot_x_o;
  assign sum_y_d = flush ? '0 : mot_y_o;
  assign sum_h_d = flush ? '0 : whl_x_o;
  assign sum_v_d = flush ? '0 : whl_y_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_h_q <= '0;
      sum_v_q <= '0;
    end else if (take_i) begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_h_q <= sum_h_d;
      sum_v_q <= sum_v_d;
    end
  end

endmodule

>>> hdl/rieco_queue.sv
// ----------------------------------------------------------------------------
// rieco_queue
// Queue of per-item result bundles, unpacked onto the result channel.
// ----------------------------------------------------------------------------
module rieco_queue #(
  parameter int unsigned SUM_WIDTH = rieco_pkg::SUM_WIDTH_DEF,
  parameter int unsigned DEPTH     = rieco_pkg::QUEUE_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  rieco_pkg::bundle_flags_t     flags_i,
  input  logic signed [SUM_WIDTH-1:0]  mot_x_i,
  input  logic signed [SUM_WIDTH-1:0]  mot_y_i,
  input  logic signed [SUM_WIDTH-1:0]  whl_x_i,
  input  logic signed [SUM_WIDTH-1:0]  whl_y_i,
  output logic                         ready_o,
  rieco_res_if.source                  res_o
);
  import rieco_pkg::*;

  // depth is a power of two so the pointers wrap on their own
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned PAY_W = 4 * SUM_WIDTH;

  bundle_flags_t     flags_q [DEPTH];
  logic [PAY_W-1:0]  pay_q   [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              mot_done_q, whl_done_q;

  bundle_flags_t     head;
  logic [PAY_W-1:0]  head_pay;
  logic              sel_mot, sel_whl, is_last, take_out, pop;

  assign head     = flags_q[rd_ptr_q];
  assign head_pay = pay_q[rd_ptr_q];
  assign ready_o  = (cnt_q < CNT_W'(DEPTH));

  assign sel_mot = head.has_motion && !mot_done_q;
  assign sel_whl = !sel_mot && head.has_wheel && !whl_done_q;

  always_comb begin
    res_o.valid    = (cnt_q != '0);
    res_o.out_code = '0;
    res_o.delta_x  = '0;
    res_o.delta_y  = '0;
    if (sel_mot) begin
      res_o.out_type = OUT_MOTION;
      res_o.delta_x  = head_pay[0*SUM_WIDTH +: SUM_WIDTH];
      res_o.delta_y  = head_pay[1*SUM_WIDTH +: SUM_WIDTH];
      is_last        = !head.has_wheel && !head.has_key;
    end else if (sel_whl) begin
      res_o.out_type = OUT_WHEEL;
      res_o.delta_x  = head_pay[2*SUM_WIDTH +: SUM_WIDTH];
      res_o.delta_y  = head_pay[3*SUM_WIDTH +: SUM_WIDTH];
      is_last        = !head.has_key;
    end else begin
      res_o.out_type = head.key_press ? OUT_PRESS : OUT_RELEASE;
      res_o.out_code = head.key_code;
      is_last        = 1'b1;
    end
    res_o.last_result = is_last;
  end

  assign take_out = res_o.valid && res_o.ready;
  assign pop      = take_out && is_last;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
      mot_done_q <= 1'b0;
      whl_done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q   <= rd_ptr_q + 1'b1;
        mot_done_q <= 1'b0;
        whl_done_q <= 1'b0;
      end else if (take_out) begin
        if (sel_mot) begin
          mot_done_q <= 1'b1;
        end else begin
          whl_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      flags_q[wr_ptr_q] <= flags_i;
      pay_q[wr_ptr_q]   <= {whl_y_i, whl_x_i, mot_y_i, mot_x_i};
    end
  end

endmodule

>>> hdl/relative_input_event_coalescer.sv
// ----------------------------------------------------------------------------
// relative_input_event_coalescer
// Sums runs of relative device events and emits motion, wheel and key items.
// ----------------------------------------------------------------------------
// evt_i takes one raw event per cycle (valid/ready). Relative deltas for X, Y
// and both wheels add into saturating sums; a key event, any other event, or
// a relative event flagged batch_last ends the run and flushes the sums.
// res_o gives up to three items per event: motion if X or Y is nonzero,
// wheel if either wheel sum is nonzero, then press/release for a key, with
// last_result marking the final item of that event.
// cfg_i writes the key remap registers at any time with ready held high;
// index 0 is the source key code, index 1 the target, other indexes ignored.
// Items are registered in the bundle queue before they show on res_o.
// Throughput: one event per cycle while the bundle queue has room; an event
// with more than one item holds res_o until its last item is taken.
// When res_o stalls the queue keeps taking events until its bundles are all
// in use, then evt_i ready drops. Reset clears the sums, the queue and sets
// the remap registers to 99 -> 210.
// ----------------------------------------------------------------------------
module relative_input_event_coalescer #(
  parameter int unsigned SUM_WIDTH   = rieco_pkg::SUM_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = rieco_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rieco_evt_if.sink   evt_i,
  rieco_cfg_if.sink   cfg_i,
  rieco_res_if.source res_o
);
  import rieco_pkg::*;

  logic [CODE_W-1:0]           remap_src_q, remap_dst_q;
  logic                        take, push, q_ready;
  bundle_flags_t               flags;
  logic signed [SUM_WIDTH-1:0] mot_x, mot_y, whl_x, whl_y;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remap_src_q <= REMAP_SRC_RST;
      remap_dst_q <= REMAP_DST_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_REMAP_SRC: remap_src_q <= cfg_i.data;
        CFG_REMAP_DST: remap_dst_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign evt_i.ready = q_ready;
  assign take        = evt_i.valid && q_ready;

  rieco_accum #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .kind_i      (evt_i.kind),
    .code_i      (evt_i.event_code),
    .value_i     (evt_i.event_value),
    .last_i      (evt_i.batch_last),
    .remap_src_i (remap_src_q),
    .remap_dst_i (remap_dst_q),
    .push_o      (push),
    .flags_o     (flags),
    .mot_x_o     (mot_x),
    .mot_y_o     (mot_y),
    .whl_x_o     (whl_x),
    .whl_y_o     (whl_y)
  );

  rieco_queue #(
    .SUM_WIDTH (SUM_WIDTH),
    .DEPTH     (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .flags_i (flags),
    .mot_x_i (mot_x),
    .mot_y_i (mot_y),
    .whl_x_i (whl_x),
    .whl_y_i (whl_y),
    .ready_o (q_ready),
    .res_o   (res_o)
  );

endmodule
